@@ rtl/core/cni_pkg.sv @@
package cni_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int JOB_DEPTH      = 4;
    localparam int RES_DEPTH      = 16;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RULE_SELECT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_WIDTH  = 2'd1;

    localparam logic [31:0] STEP_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        RULE_TRAP   = 2'd0,
        RULE_SIMP13 = 2'd1,
        RULE_SIMP38 = 2'd2,
        RULE_RSVD   = 2'd3
    } t_rule;

    typedef struct packed {
        logic        err;
        logic        neg;
        logic        clip;
        t_rule       rule;
        logic [47:0] mag;
    } t_job;

    typedef struct packed {
        logic signed [47:0] integral;
        logic               count_error;
        logic               saturated;
    } t_res;

endpackage

@@ rtl/core/cni_fifo.sv @@
module cni_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ rtl/core/cni_front.sv @@
module cni_front #(
    parameter int MAX_POINTS = cni_pkg::MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic signed [31:0] i_sample_value,
    input  logic               i_is_last,
    input  cni_pkg::t_rule     i_rule,
    output logic               o_job_push,
    output cni_pkg::t_job      o_job
);

    localparam int IDX_W = $clog2(MAX_POINTS + 1);

    logic signed [47:0] r_sum, n_sum;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [1:0]         r_ph, n_ph;
    logic               r_ovf, n_ovf;
    logic               r_clip, n_clip;

    logic               at_cap;
    logic [2:0]         w_int;
    logic [2:0]         weight;
    logic signed [34:0] v_ext;
    logic signed [34:0] prod;
    logic signed [49:0] sum_ext;
    logic               pos_ovf;
    logic               neg_ovf;
    logic signed [47:0] sum_clamped;
    logic signed [47:0] sum_final;
    logic               clip_final;
    logic               rule_err;

    always_comb begin
        at_cap = (r_idx == IDX_W'(MAX_POINTS));

        case (i_rule)
            cni_pkg::RULE_SIMP13: w_int = r_idx[0] ? 3'd4 : 3'd2;
            cni_pkg::RULE_SIMP38: w_int = (r_ph == 2'd0) ? 3'd2 : 3'd3;
            default:              w_int = 3'd2;
        endcase
        weight = ((r_idx == '0) || i_is_last) ? 3'd1 : w_int;

        v_ext = 35'(i_sample_value);
        case (weight)
            3'd2:    prod = v_ext <<< 1;
            3'd3:    prod = (v_ext <<< 1) + v_ext;
            3'd4:    prod = v_ext <<< 2;
            default: prod = v_ext;
        endcase

        sum_ext = 50'(r_sum) + 50'(prod);
        pos_ovf = !sum_ext[49] && (sum_ext[48] || sum_ext[47]);
        neg_ovf = sum_ext[49] && !(sum_ext[48] && sum_ext[47]);
        if (pos_ovf) begin
            sum_clamped = 48'sh7FFF_FFFF_FFFF;
        end else if (neg_ovf) begin
            sum_clamped = 48'sh8000_0000_0000;
        end else begin
            sum_clamped = sum_ext[47:0];
        end

        sum_final  = at_cap ? r_sum : sum_clamped;
        clip_final = r_clip || (!at_cap && (pos_ovf || neg_ovf));

        unique case (i_rule)
            cni_pkg::RULE_TRAP:   rule_err = (r_idx == '0);
            cni_pkg::RULE_SIMP13: rule_err = (r_idx < IDX_W'(2)) || r_idx[0];
            cni_pkg::RULE_SIMP38: rule_err = (r_idx < IDX_W'(3)) || (r_ph != 2'd0);
            default:              rule_err = 1'b1;
        endcase

        o_job_push = i_accept && i_is_last;
        o_job.err  = rule_err || r_ovf || at_cap;
        o_job.neg  = sum_final[47];
        o_job.clip = clip_final;
        o_job.rule = i_rule;
        o_job.mag  = sum_final[47] ? 48'(-sum_final) : 48'(sum_final);

        n_sum  = r_sum;
        n_idx  = r_idx;
        n_ph   = r_ph;
        n_ovf  = r_ovf;
        n_clip = r_clip;
        if (i_accept) begin
            if (i_is_last) begin
                n_sum  = '0;
                n_idx  = '0;
                n_ph   = '0;
                n_ovf  = 1'b0;
                n_clip = 1'b0;
            end else if (at_cap) begin
                n_ovf = 1'b1;
            end else begin
                n_sum  = sum_clamped;
                n_clip = clip_final;
                n_idx  = r_idx + 1'b1;
                n_ph   = (r_ph == 2'd2) ? 2'd0 : r_ph + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_idx  <= '0;
            r_ph   <= '0;
            r_ovf  <= 1'b0;
            r_clip <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_idx  <= n_idx;
            r_ph   <= n_ph;
            r_ovf  <= n_ovf;
            r_clip <= n_clip;
        end
    end

endmodule

@@ rtl/core/cni_back.sv @@
module cni_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_issue,
    input  cni_pkg::t_job i_job,
    input  logic [31:0]   i_step,
    output logic          o_res_valid,
    output cni_pkg::t_res o_res
);

    localparam logic [19:0] DIV3_MUL = 20'd699051;

    typedef struct packed {
        logic          err;
        logic          neg;
        logic          clip;
        cni_pkg::t_rule rule;
    } t_meta;

    function automatic logic [18:0] div3_chunk(input logic [18:0] x);
        logic [38:0] p;
        logic [16:0] q;
        logic [18:0] r;
        p = 39'(x) * 39'(DIV3_MUL);
        q = p[37:21];
        r = x - 19'(q) - 19'({q, 1'b0});
        return {r[1:0], q};
    endfunction

    logic        r_vld [1:7];
    t_meta       r_meta [1:7];
    logic [63:0] r1_plo;
    logic [47:0] r1_phi;
    logic [79:0] r2_prod;
    logic [81:0] r3_tri;
    logic [50:0] r4_y, r5_y, r6_y, r7_y;
    logic        r4_big, r5_big, r6_big, r7_big;
    logic [1:0]  r5_rem, r6_rem;

    logic [81:0] rnd_sum;
    logic [65:0] y_full;
    logic [65:0] y_shift;
    logic [18:0] d5, d6, d7;
    logic        is_div3 [5:7];

    always_comb begin
        unique case (r_meta[3].rule)
            cni_pkg::RULE_SIMP13: rnd_sum = r3_tri + 82'd98304;
            cni_pkg::RULE_SIMP38: rnd_sum = r3_tri + 82'd262144;
            default:              rnd_sum = r3_tri + 82'd65536;
        endcase
        y_full = rnd_sum[81:16];
        unique case (r_meta[3].rule)
            cni_pkg::RULE_SIMP13: y_shift = y_full;
            cni_pkg::RULE_SIMP38: y_shift = y_full >> 3;
            default:              y_shift = y_full >> 1;
        endcase

        is_div3[5] = (r_meta[4].rule == cni_pkg::RULE_SIMP13);
        is_div3[6] = (r_meta[5].rule == cni_pkg::RULE_SIMP13);
        is_div3[7] = (r_meta[6].rule == cni_pkg::RULE_SIMP13);
        d5 = is_div3[5] ? div3_chunk({2'b00, r4_y[50:34]}) : {2'b00, r4_y[50:34]};
        d6 = is_div3[6] ? div3_chunk({r5_rem, r5_y[33:17]}) : {2'b00, r5_y[33:17]};
        d7 = is_div3[7] ? div3_chunk({r6_rem, r6_y[16:0]}) : {2'b00, r6_y[16:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 1; k <= 7; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[1] <= i_issue;
            for (int k = 2; k <= 7; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_meta[1] <= '{err: i_job.err, neg: i_job.neg, clip: i_job.clip, rule: i_job.rule};
        for (int k = 2; k <= 7; k++) begin
            r_meta[k] <= r_meta[k-1];
        end

        r1_plo  <= 64'(i_job.mag[31:0]) * 64'(i_step);
        r1_phi  <= 48'(i_job.mag[47:32]) * 48'(i_step);
        r2_prod <= 80'(r1_plo) + {r1_phi, 32'd0};
        if (r_meta[2].rule == cni_pkg::RULE_SIMP38) begin
            r3_tri <= 82'(r2_prod) + 82'({r2_prod, 1'b0});
        end else begin
            r3_tri <= 82'(r2_prod);
        end

        r4_y   <= y_shift[50:0];
        r4_big <= |y_shift[65:51];

        r5_y   <= {d5[16:0], r4_y[33:0]};
        r5_rem <= d5[18:17];
        r5_big <= r4_big;

        r6_y   <= {r5_y[50:34], d6[16:0], r5_y[16:0]};
        r6_rem <= d6[18:17];
        r6_big <= r5_big;

        r7_y   <= {r6_y[50:17], d7[16:0]};
        r7_big <= r6_big;
    end

    always_comb begin
        o_res_valid = r_vld[7];
        o_res.count_error = r_meta[7].err;
        o_res.integral    = '0;
        o_res.saturated   = 1'b0;
        if (!r_meta[7].err) begin
            o_res.saturated = r_meta[7].clip;
            if (r_meta[7].neg) begin
                if (r7_big || (r7_y > 51'h0_8000_0000_0000)) begin
                    o_res.integral  = 48'sh8000_0000_0000;
                    o_res.saturated = 1'b1;
                end else begin
                    o_res.integral = -$signed(r7_y[47:0]);
                end
            end else begin
                if (r7_big || (r7_y > 51'h0_7FFF_FFFF_FFFF)) begin
                    o_res.integral  = 48'sh7FFF_FFFF_FFFF;
                    o_res.saturated = 1'b1;
                end else begin
                    o_res.integral = $signed(r7_y[47:0]);
                end
            end
        end
    end

endmodule

@@ rtl/core/composite_newton_cotes_integrator_top.sv @@
// Composite trapezoid / Simpson integrator over a stream of Q16.16 samples.
// Samples enter through a queue-style port: a request is taken when push is
// high and full is low, one per cycle. The sample with i_is_last set closes
// the interval and produces one result; other samples produce none.
// Results leave through a queue-style port: the oldest result is shown while
// empty is low and is taken when pop is high.
// The front stage adds each weighted sample into a register as it is taken, so
// samples stream at one per cycle while full is low. A closing sample passes
// through the job queue into the back end, a pipelined multiply, round and
// divide-by-three unit, and from there into the result queue.
// A four-entry queue sits between front and back, and a sixteen-entry result
// queue absorbs a stalled receiver. Once sixteen results are waiting or in
// flight, closing samples wait in the first queue; full rises when four of
// them wait there, and it then holds off every request, closing or not.
// The configuration port is always ready; the user must write it only while
// the block is idle, as the block itself does not enforce this. Reset selects
// the trapezoid rule, a 1.0 step width, an empty interval and empty queues.
module composite_newton_cotes_integrator_top #(
    parameter int MAX_POINTS = cni_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cni_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic signed [31:0]            i_sample_value,
    input  logic                          i_is_last,
    input  logic                          pop,
    output logic                          empty,
    output logic signed [47:0]            o_integral,
    output logic                          o_count_error,
    output logic                          o_saturated
);

    localparam int PEND_W = $clog2(cni_pkg::RES_DEPTH + 1);

    cni_pkg::t_rule   r_rule;
    logic [31:0]      r_step;
    logic [PEND_W-1:0] r_pend, n_pend;

    logic             accept;
    logic             job_push;
    cni_pkg::t_job    job_in;
    cni_pkg::t_job    job_out;
    logic             job_empty;
    logic             issue;
    logic             res_valid;
    cni_pkg::t_res    res_in;
    cni_pkg::t_res    res_out;
    logic             res_pop;
    logic             res_full;

    assign o_cfg_ready = 1'b1;
    assign accept      = push && !full;
    assign issue       = !job_empty && (r_pend != PEND_W'(cni_pkg::RES_DEPTH));
    assign res_pop     = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule <= cni_pkg::RULE_TRAP;
            r_step <= cni_pkg::STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cni_pkg::CFG_RULE_SELECT: r_rule <= cni_pkg::t_rule'(i_cfg_data[1:0]);
                cni_pkg::CFG_STEP_WIDTH:  r_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (issue && !res_pop) begin
            n_pend = r_pend + 1'b1;
        end else if (res_pop && !issue) begin
            n_pend = r_pend - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    cni_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_sample_value (i_sample_value),
        .i_is_last      (i_is_last),
        .i_rule         (r_rule),
        .o_job_push     (job_push),
        .o_job          (job_in)
    );

    cni_fifo #(
        .WIDTH($bits(cni_pkg::t_job)),
        .DEPTH(cni_pkg::JOB_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (issue),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    cni_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue     (issue),
        .i_job       (job_out),
        .i_step      (r_step),
        .o_res_valid (res_valid),
        .o_res       (res_in)
    );

    cni_fifo #(
        .WIDTH($bits(cni_pkg::t_res)),
        .DEPTH(cni_pkg::RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid && !res_full),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (res_pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign o_integral    = res_out.integral;
    assign o_count_error = res_out.count_error;
    assign o_saturated   = res_out.saturated;

endmodule
